@@ hw/rtl/svsf_pkg.sv @@
`timescale 1ns / 1ps
package svsf_pkg;

  localparam int BONE_COUNT     = 64;
  localparam int BONE_W         = 6;
  localparam int VERTEX_COUNT   = 1024;
  localparam int SLOT_W         = 10;
  localparam int ROW_ELEMS      = 12;
  localparam int ELEM_W         = 4;
  localparam int WEIGHTS        = 4;
  localparam int SPRING_GAIN    = 200;
  localparam int DAMPING_GAIN   = 5;
  localparam int STAGES         = 10;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  typedef enum logic [2:0] {
    CFG_TRANS_X = 3'd0,
    CFG_TRANS_Y = 3'd1,
    CFG_TRANS_Z = 3'd2,
    CFG_STIFF   = 3'd3,
    CFG_TSTEP   = 3'd4,
    CFG_MULTI   = 3'd5
  } cfg_idx_t;

  typedef logic signed [31:0] word_t;
  typedef logic [2:0][31:0] vec3_t;
  typedef logic [ROW_ELEMS-1:0][31:0] bone_row_t;

  typedef struct packed {
    logic               op;
    logic [5:0]         matrix_sel;
    logic [3:0]         element_sel;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [9:0]         vertex_slot;
    logic [23:0]        bone_indices;
    logic [31:0]        weights_low;
    logic [31:0]        weights_high;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [9:0]         out_slot;
  } out_item_t;

  typedef struct packed {
    vec3_t pos;
    vec3_t vel;
  } fol_state_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic              restart;
  } stage_ctl_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    word_t r;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      r = 32'sh7fffffff;
    end else if (v < lo) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // q16.16 times q16.16, floor to q16.16 (wide)
  function automatic logic signed [47:0] mul_q16(input word_t a, input word_t b);
    logic signed [63:0] f;
    f = a * b;
    return f[63:16];
  endfunction

  // signed times unsigned q0.16 fraction, floor
  function automatic logic signed [32:0] mul_frac(input word_t a, input logic [15:0] w);
    logic signed [48:0] f;
    logic signed [16:0] ws;
    ws = $signed({1'b0, w});
    f = a * ws;
    return f[48:16];
  endfunction

  function automatic logic signed [46:0] mul_stiff(input word_t a, input logic [30:0] s);
    logic signed [62:0] f;
    logic signed [31:0] ss;
    ss = $signed({1'b0, s});
    f = a * ss;
    return f[62:16];
  endfunction

endpackage

@@ hw/rtl/svsf_bone_mem.sv @@
`timescale 1ns / 1ps
module svsf_bone_mem (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [svsf_pkg::BONE_W-1:0]            wr_bone,
  input  logic [svsf_pkg::ELEM_W-1:0]            wr_elem,
  input  logic [31:0]                            wr_data,
  input  logic                                   rd_en,
  input  logic [svsf_pkg::WEIGHTS-1:0][svsf_pkg::BONE_W-1:0] rd_bone,
  output svsf_pkg::bone_row_t [svsf_pkg::WEIGHTS-1:0] rd_row
);
  import svsf_pkg::*;

  // one copy per weight so all four bones read in the same cycle
  bone_row_t bone_mem_r [WEIGHTS][BONE_COUNT];
  bone_row_t [WEIGHTS-1:0] rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < WEIGHTS; k++) begin
        bone_mem_r[k][wr_bone][wr_elem] <= wr_data;
      end
    end
    if (rd_en) begin
      for (int k = 0; k < WEIGHTS; k++) begin
        rd_row_r[k] <= bone_mem_r[k][rd_bone[k]];
      end
    end
  end

  assign rd_row = rd_row_r;
endmodule

@@ hw/rtl/svsf_state_mem.sv @@
`timescale 1ns / 1ps
module svsf_state_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [svsf_pkg::SLOT_W-1:0] wr_addr,
  input  svsf_pkg::fol_state_t        wr_data,
  input  logic                        rd_en,
  input  logic [svsf_pkg::SLOT_W-1:0] rd_addr,
  output svsf_pkg::fol_state_t        rd_data
);
  import svsf_pkg::*;

  fol_state_t state_mem_r [VERTEX_COUNT];
  fol_state_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= state_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

@@ hw/rtl/svsf_skin.sv @@
`timescale 1ns / 1ps
module svsf_skin (
  input  logic                                       clk,
  input  logic [4:0]                                 ld,
  input  svsf_pkg::in_item_t                         in_pld,
  input  svsf_pkg::bone_row_t [svsf_pkg::WEIGHTS-1:0] bone_row,
  input  logic                                       multi_bone,
  input  svsf_pkg::vec3_t                            trans,
  output svsf_pkg::vec3_t                            target
);
  import svsf_pkg::*;

  vec3_t p1_r;
  logic [WEIGHTS-1:0][15:0] w1_r, w2_r, w3_r;
  logic signed [47:0] pr2_r [WEIGHTS][3][3];
  logic [WEIGHTS-1:0][2:0][31:0] off2_r;
  logic [WEIGHTS-1:0][2:0][31:0] t3_r;
  logic signed [32:0] wp4_r [WEIGHTS][3];
  vec3_t t0_4_r;
  vec3_t target5_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p1_r <= {in_pld.pos_z, in_pld.pos_y, in_pld.pos_x};
      w1_r <= {in_pld.weights_high, in_pld.weights_low};
    end
    if (ld[1]) begin
      w2_r <= w1_r;
      for (int k = 0; k < WEIGHTS; k++) begin
        for (int r = 0; r < 3; r++) begin
          off2_r[k][r] <= bone_row[k][r*4+3];
          for (int c = 0; c < 3; c++) begin
            pr2_r[k][r][c] <= mul_q16($signed(bone_row[k][r*4+c]), $signed(p1_r[c]));
          end
        end
      end
    end
    if (ld[2]) begin
      w3_r <= w2_r;
      for (int k = 0; k < WEIGHTS; k++) begin
        for (int r = 0; r < 3; r++) begin
          t3_r[k][r] <= sat32(64'($signed(off2_r[k][r])) + 64'(pr2_r[k][r][0])
                              + 64'(pr2_r[k][r][1]) + 64'(pr2_r[k][r][2]));
        end
      end
    end
    if (ld[3]) begin
      t0_4_r <= t3_r[0];
      for (int k = 0; k < WEIGHTS; k++) begin
        for (int r = 0; r < 3; r++) begin
          wp4_r[k][r] <= mul_frac($signed(t3_r[k][r]), w3_r[k]);
        end
      end
    end
    if (ld[4]) begin
      for (int r = 0; r < 3; r++) begin
        if (multi_bone) begin
          target5_r[r] <= sat32(64'($signed(trans[r])) + 64'(wp4_r[0][r])
                                + 64'(wp4_r[1][r]) + 64'(wp4_r[2][r]) + 64'(wp4_r[3][r]));
        end else begin
          target5_r[r] <= t0_4_r[r];
        end
      end
    end
  end

  assign target = target5_r;
endmodule

@@ hw/rtl/svsf_spring.sv @@
`timescale 1ns / 1ps
module svsf_spring (
  input  logic                 clk,
  input  logic [4:0]           ld,
  input  svsf_pkg::vec3_t      tgt,
  input  svsf_pkg::fol_state_t cur,
  input  logic [30:0]          stiffness,
  input  logic [15:0]          time_step,
  input  logic                 restart,
  output svsf_pkg::fol_state_t wb
);
  import svsf_pkg::*;

  vec3_t tgt6_r, tgt7_r, tgt8_r, tgt9_r, tgt10_r;
  vec3_t pos6_r, pos7_r, pos8_r, pos9_r, pos10_r;
  vec3_t vel6_r, vel7_r, vel8_r;
  logic signed [46:0] m6_r [3];
  logic signed [46:0] m6_nxt [3];
  vec3_t a7_r, a7_nxt;
  logic signed [32:0] pa8_r [3];
  logic signed [32:0] pa8_nxt [3];
  vec3_t nv9_r, nv9_nxt, nv10_r;
  logic signed [32:0] pn10_r [3];
  logic signed [32:0] pn10_nxt [3];
  vec3_t np;

  always_comb begin
    word_t d;
    word_t f;
    for (int r = 0; r < 3; r++) begin
      d = sat32(64'($signed(tgt[r])) - 64'($signed(cur.pos[r])));
      m6_nxt[r] = mul_stiff(d, stiffness);
      f = sat32(64'(m6_r[r]) * 64'(SPRING_GAIN));
      a7_nxt[r] = sat32(64'(f) - 64'($signed(vel6_r[r])) * 64'(DAMPING_GAIN));
      pa8_nxt[r] = mul_frac($signed(a7_r[r]), time_step);
      nv9_nxt[r] = sat32(64'($signed(vel8_r[r])) + 64'(pa8_r[r]));
      pn10_nxt[r] = mul_frac($signed(nv9_r[r]), time_step);
      np[r] = sat32(64'($signed(pos10_r[r])) + 64'(pn10_r[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      tgt6_r <= tgt;
      pos6_r <= cur.pos;
      vel6_r <= cur.vel;
      m6_r   <= m6_nxt;
    end
    if (ld[1]) begin
      tgt7_r <= tgt6_r;
      pos7_r <= pos6_r;
      vel7_r <= vel6_r;
      a7_r   <= a7_nxt;
    end
    if (ld[2]) begin
      tgt8_r <= tgt7_r;
      pos8_r <= pos7_r;
      vel8_r <= vel7_r;
      pa8_r  <= pa8_nxt;
    end
    if (ld[3]) begin
      tgt9_r <= tgt8_r;
      pos9_r <= pos8_r;
      nv9_r  <= nv9_nxt;
    end
    if (ld[4]) begin
      tgt10_r <= tgt9_r;
      pos10_r <= pos9_r;
      nv10_r  <= nv9_r;
      pn10_r  <= pn10_nxt;
    end
  end

  always_comb begin
    if (restart) begin
      wb.pos = tgt10_r;
      wb.vel = '0;
    end else begin
      wb.pos = np;
      wb.vel = nv10_r;
    end
  end
endmodule

@@ hw/rtl/skinned_vertex_spring_follow.sv @@
`timescale 1ns / 1ps
// Skinned vertex with a spring-damped follower. One item per cycle is taken
// unless in_stall is high: a load item writes one bone matrix element at once
// (element index below 12), a vertex item runs a pipeline (bone transforms,
// weight blend, spring step) and leaves one result. The follower state of
// each slot is read from its memory four stages in and written back at the
// last stage, so a vertex item for a slot that is still in the pipeline
// waits until that earlier item has left it; items for other slots follow
// back to back. Bone matrices live in four copies of a 64 x 12 word memory,
// one read per weight. No clearing pass: matrix and follower entries must
// be written (a load, a restart frame) before they are used.
module skinned_vertex_spring_follow (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  svsf_pkg::in_item_t  in_pld,
  output logic                out_valid,
  input  logic                out_stall,
  output svsf_pkg::out_item_t out_pld,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import svsf_pkg::*;

  vec3_t       trans_r;
  logic [30:0] stiff_r;
  logic [15:0] ts_r;
  logic        multi_r;

  stage_ctl_t  ctl_r [1:STAGES];
  logic [STAGES+1:1] take;
  logic        hit;
  logic        in_acc;
  logic        wb_en;
  logic        out_valid_r;
  out_item_t   out_pld_r;

  logic [WEIGHTS-1:0][BONE_W-1:0] rd_bone;
  bone_row_t [WEIGHTS-1:0] bone_row;
  fol_state_t  cur_state;
  fol_state_t  wb_state;
  vec3_t       target;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r <= '0;
      stiff_r <= '0;
      ts_r    <= '0;
      multi_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRANS_X: trans_r[0] <= cfg_data;
        CFG_TRANS_Y: trans_r[1] <= cfg_data;
        CFG_TRANS_Z: trans_r[2] <= cfg_data;
        CFG_STIFF:   stiff_r    <= cfg_data[30:0];
        CFG_TSTEP:   ts_r       <= cfg_data[15:0];
        CFG_MULTI:   multi_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    take[STAGES+1] = !out_valid_r || !out_stall;
    for (int k = STAGES; k >= 1; k--) begin
      take[k] = !ctl_r[k].valid || take[k+1];
    end
  end

  // same-slot interlock for the follower read-modify-write
  always_comb begin
    hit = 1'b0;
    for (int k = 1; k <= STAGES; k++) begin
      hit = hit || (ctl_r[k].valid && ctl_r[k].slot == in_pld.vertex_slot);
    end
  end

  assign in_stall = !take[1] || (in_pld.op == OP_VERTEX && hit);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= STAGES; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      if (take[1]) begin
        ctl_r[1] <= '{valid: in_acc && in_pld.op == OP_VERTEX,
                      slot: in_pld.vertex_slot, restart: in_pld.restart};
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (take[k]) begin
          ctl_r[k] <= ctl_r[k-1];
        end
      end
    end
  end

  always_comb begin
    rd_bone[0] = multi_r ? in_pld.bone_indices[BONE_W-1:0] : '0;
    for (int k = 1; k < WEIGHTS; k++) begin
      rd_bone[k] = in_pld.bone_indices[k*BONE_W +: BONE_W];
    end
  end

  svsf_bone_mem u_bone_mem (
    .clk     (clk),
    .wr_en   (in_acc && in_pld.op == OP_LOAD && in_pld.element_sel < ELEM_W'(ROW_ELEMS)),
    .wr_bone (in_pld.matrix_sel),
    .wr_elem (in_pld.element_sel),
    .wr_data (in_pld.element_value),
    .rd_en   (take[1]),
    .rd_bone (rd_bone),
    .rd_row  (bone_row)
  );

  svsf_skin u_skin (
    .clk        (clk),
    .ld         (take[5:1]),
    .in_pld     (in_pld),
    .bone_row   (bone_row),
    .multi_bone (multi_r),
    .trans      (trans_r),
    .target     (target)
  );

  assign wb_en = ctl_r[STAGES].valid && take[STAGES+1];

  svsf_state_mem u_state_mem (
    .clk     (clk),
    .wr_en   (wb_en),
    .wr_addr (ctl_r[STAGES].slot),
    .wr_data (wb_state),
    .rd_en   (take[5]),
    .rd_addr (ctl_r[4].slot),
    .rd_data (cur_state)
  );

  svsf_spring u_spring (
    .clk       (clk),
    .ld        (take[STAGES:6]),
    .tgt       (target),
    .cur       (cur_state),
    .stiffness (stiff_r),
    .time_step (ts_r),
    .restart   (ctl_r[STAGES].restart),
    .wb        (wb_state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take[STAGES+1]) begin
      out_valid_r <= ctl_r[STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take[STAGES+1]) begin
      out_pld_r <= '{out_x: wb_state.pos[0], out_y: wb_state.pos[1],
                     out_z: wb_state.pos[2], out_slot: ctl_r[STAGES].slot};
    end
  end

  assign out_valid = out_valid_r;
  assign out_pld   = out_pld_r;

  a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_en && take[5] && ctl_r[4].valid) |-> (ctl_r[4].slot != ctl_r[STAGES].slot))
    else $error("follower read and writeback hit the same slot");

  a_load_no_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_pld.op == OP_LOAD) |=> !ctl_r[1].valid)
    else $error("load item entered the vertex pipeline");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl_r[STAGES].valid))
    else $error("result without a vertex in the last stage");
endmodule
